// ===== rtl/core/http_message_framer_core_macros.svh =====
// ----------------------------------------------------------------------------
// http message framer assertion macros
// shorthand for the concurrent checks on the framer ports
// ----------------------------------------------------------------------------
`ifndef HTTP_MESSAGE_FRAMER_CORE_MACROS_SVH
`define HTTP_MESSAGE_FRAMER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define HMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define HMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hmf_pkg
// types, codes and character helpers shared by the http message framer
// ----------------------------------------------------------------------------
package hmf_pkg;

	localparam int HDR_BITS  = 16;
	localparam int BODY_BITS = 24;
	localparam int CNT_BITS  = ((HDR_BITS > BODY_BITS) ? HDR_BITS : BODY_BITS) + 1;
	localparam int MAG_BITS  = 31;
	localparam int CFG_BITS  = (HDR_BITS > BODY_BITS) ? HDR_BITS : BODY_BITS;
	localparam int CL_LEN    = 18;
	localparam int CLP_BITS  = $clog2(CL_LEN + 1);

	localparam logic [CNT_BITS-1:0]  CNT_MAX = {CNT_BITS{1'b1}};
	localparam logic [MAG_BITS-1:0]  MAG_MAX = {MAG_BITS{1'b1}};
	localparam logic [HDR_BITS-1:0]  MAX_HDR_RESET  = HDR_BITS'(8192);
	localparam logic [BODY_BITS-1:0] MAX_BODY_RESET = BODY_BITS'(1048576);

	// request kinds
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// verdict codes
	localparam logic [2:0] ST_NEED_MORE = 3'd0;
	localparam logic [2:0] ST_COMPLETE  = 3'd1;
	localparam logic [2:0] ST_HDR_LONG  = 3'd2;
	localparam logic [2:0] ST_BODY_LONG = 3'd3;
	localparam logic [2:0] ST_NEGATIVE  = 3'd4;

	// register indexes
	localparam logic [0:0] CFG_MAX_HDR  = 1'b0;
	localparam logic [0:0] CFG_MAX_BODY = 1'b1;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       accept_short;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [HDR_BITS-1:0]  header_len;
		logic [BODY_BITS-1:0] body_len;
	} out_item_t;

	// tracker control from the top level
	typedef struct packed {
		logic       take;
		logic       clear;
		logic [7:0] data_byte;
	} trk_ctrl_t;

	// tracker view handed to the verdict logic
	typedef struct packed {
		logic [CNT_BITS-1:0] cnt;
		logic                hdr_found;
		logic [CNT_BITS-1:0] hdr_len;
		logic                cl_seen;
		logic                cl_neg;
		logic [MAG_BITS-1:0] cl_mag;
	} trk_state_t;

	// "\r\nContent-Length: " one character per position
	function automatic logic [7:0] cl_char(input logic [CLP_BITS-1:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:    ch = CH_CR;
			5'd1:    ch = CH_LF;
			5'd2:    ch = 8'h43;
			5'd3:    ch = 8'h6F;
			5'd4:    ch = 8'h6E;
			5'd5:    ch = 8'h74;
			5'd6:    ch = 8'h65;
			5'd7:    ch = 8'h6E;
			5'd8:    ch = 8'h74;
			5'd9:    ch = 8'h2D;
			5'd10:   ch = 8'h4C;
			5'd11:   ch = 8'h65;
			5'd12:   ch = 8'h6E;
			5'd13:   ch = 8'h67;
			5'd14:   ch = 8'h74;
			5'd15:   ch = 8'h68;
			5'd16:   ch = 8'h3A;
			5'd17:   ch = CH_SPACE;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

// ===== rtl/core/hmf_tracker.sv =====
// ----------------------------------------------------------------------------
// hmf_tracker
// byte counter, terminator and content-length matchers, value parser
// ----------------------------------------------------------------------------
module hmf_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hmf_pkg::trk_ctrl_t     ctrl,
	output hmf_pkg::trk_state_t    state
);

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_SIGN   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam int PROD_BITS = hmf_pkg::MAG_BITS + 4;

	logic [hmf_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
	logic                         hdr_found_q, hdr_found_d;
	logic [hmf_pkg::CNT_BITS-1:0] hdr_len_q, hdr_len_d;
	logic [1:0]                   term_prog_q, term_prog_d;
	logic [hmf_pkg::CLP_BITS-1:0] cl_prog_q, cl_prog_d;
	logic [2:0]                   phase_q, phase_d;
	logic                         neg_q, neg_d;
	logic [hmf_pkg::MAG_BITS-1:0] mag_q, mag_d;

	logic [7:0]                   c;
	logic                         digit;
	logic                         term_hit;
	logic [PROD_BITS-1:0]         prod;
	logic [hmf_pkg::MAG_BITS-1:0] mag_next;

	assign c     = ctrl.data_byte;
	assign digit = (c >= hmf_pkg::CH_ZERO) && (c <= hmf_pkg::CH_NINE);

	// mag * 10 + digit, clamped
	assign prod = (PROD_BITS'(mag_q) << 3) + (PROD_BITS'(mag_q) << 1) + PROD_BITS'(c[3:0]);
	assign mag_next = (prod > PROD_BITS'(hmf_pkg::MAG_MAX)) ? hmf_pkg::MAG_MAX :
		prod[hmf_pkg::MAG_BITS-1:0];

	assign term_hit = (c == (term_prog_q[0] ? hmf_pkg::CH_LF : hmf_pkg::CH_CR));

	always_comb begin
		cnt_d       = cnt_q;
		hdr_found_d = hdr_found_q;
		hdr_len_d   = hdr_len_q;
		term_prog_d = term_prog_q;
		cl_prog_d   = cl_prog_q;
		phase_d     = phase_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		if (ctrl.clear) begin
			cnt_d       = '0;
			hdr_found_d = 1'b0;
			hdr_len_d   = '0;
			term_prog_d = '0;
			cl_prog_d   = '0;
			phase_d     = PH_SEARCH;
			neg_d       = 1'b0;
			mag_d       = '0;
		end else if (ctrl.take) begin
			cnt_d = (cnt_q == hmf_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
			if (!hdr_found_q) begin
				if (phase_q == PH_SEARCH) begin
					if (c == hmf_pkg::cl_char(cl_prog_q)) begin
						cl_prog_d = cl_prog_q + 1'b1;
						if (cl_prog_q == hmf_pkg::CLP_BITS'(hmf_pkg::CL_LEN - 1)) begin
							phase_d = PH_SPACE;
						end
					end else begin
						cl_prog_d = (c == hmf_pkg::CH_CR) ? hmf_pkg::CLP_BITS'(1) : '0;
					end
				end else if (phase_q != PH_DONE) begin
					if ((phase_q == PH_SPACE) && hmf_pkg::is_ws(c)) begin
						phase_d = PH_SPACE;
					end else if ((phase_q == PH_SPACE) &&
						((c == hmf_pkg::CH_PLUS) || (c == hmf_pkg::CH_MINUS))) begin
						neg_d   = (c == hmf_pkg::CH_MINUS);
						phase_d = PH_SIGN;
					end else if (!digit) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_DIGITS;
						mag_d   = mag_next;
					end
				end
				if (term_hit) begin
					term_prog_d = term_prog_q + 1'b1;
					if (term_prog_q == 2'd3) begin
						hdr_found_d = 1'b1;
						hdr_len_d   = cnt_d;
					end
				end else begin
					term_prog_d = (c == hmf_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			hdr_found_q <= 1'b0;
			hdr_len_q   <= '0;
			term_prog_q <= '0;
			cl_prog_q   <= '0;
			phase_q     <= PH_SEARCH;
			neg_q       <= 1'b0;
			mag_q       <= '0;
		end else begin
			cnt_q       <= cnt_d;
			hdr_found_q <= hdr_found_d;
			hdr_len_q   <= hdr_len_d;
			term_prog_q <= term_prog_d;
			cl_prog_q   <= cl_prog_d;
			phase_q     <= phase_d;
			neg_q       <= neg_d;
			mag_q       <= mag_d;
		end
	end

	assign state.cnt       = cnt_q;
	assign state.hdr_found = hdr_found_q;
	assign state.hdr_len   = hdr_len_q;
	assign state.cl_seen   = (phase_q != PH_SEARCH);
	assign state.cl_neg    = neg_q;
	assign state.cl_mag    = mag_q;

endmodule

// ===== rtl/core/hmf_verdict.sv =====
// ----------------------------------------------------------------------------
// hmf_verdict
// limit checks and length framing for a check request
// ----------------------------------------------------------------------------
module hmf_verdict (
	input  hmf_pkg::trk_state_t             state,
	input  logic [hmf_pkg::HDR_BITS-1:0]    max_hdr,
	input  logic [hmf_pkg::BODY_BITS-1:0]   max_body,
	input  logic                            accept_short,
	output hmf_pkg::out_item_t              result,
	output logic                            done
);

	logic [hmf_pkg::CNT_BITS-1:0] body;
	logic [hmf_pkg::MAG_BITS-1:0] body_w;
	logic [hmf_pkg::CNT_BITS-1:0] body_cut;
	logic [2:0]                   status;

	assign body   = state.cnt - state.hdr_len;
	assign body_w = hmf_pkg::MAG_BITS'(body);

	always_comb begin
		status   = hmf_pkg::ST_COMPLETE;
		body_cut = body;
		if (state.cnt == '0) begin
			status = hmf_pkg::ST_NEED_MORE;
		end else if (!state.hdr_found) begin
			status = (state.cnt > hmf_pkg::CNT_BITS'(max_hdr)) ? hmf_pkg::ST_HDR_LONG :
				hmf_pkg::ST_NEED_MORE;
		end else if (state.hdr_len >= hmf_pkg::CNT_BITS'(max_hdr)) begin
			status = hmf_pkg::ST_HDR_LONG;
		end else if (body >= hmf_pkg::CNT_BITS'(max_body)) begin
			status = hmf_pkg::ST_BODY_LONG;
		end else if (state.cl_seen) begin
			if (state.cl_neg && (state.cl_mag != '0)) begin
				status = hmf_pkg::ST_NEGATIVE;
			end else if ((body_w < state.cl_mag) && !accept_short) begin
				status = hmf_pkg::ST_NEED_MORE;
			end else if (body_w > state.cl_mag) begin
				body_cut = state.cl_mag[hmf_pkg::CNT_BITS-1:0];
			end
		end
	end

	assign done              = (status != hmf_pkg::ST_NEED_MORE);
	assign result.status     = status;
	assign result.header_len = (status == hmf_pkg::ST_COMPLETE) ?
		state.hdr_len[hmf_pkg::HDR_BITS-1:0] : '0;
	assign result.body_len   = (status == hmf_pkg::ST_COMPLETE) ?
		body_cut[hmf_pkg::BODY_BITS-1:0] : '0;

endmodule

// ===== rtl/core/http_message_framer_core.sv =====
// ----------------------------------------------------------------------------
// http message framer core
// a check's verdict goes through the input register and then the result register
// throughput: one request per cycle, data bytes and checks alike; a check waits
// only while an earlier verdict is still unclaimed on result
// reset: arst_n clears all framing state and loads the default length limits;
// requests are taken only once run_q has been set after release
// ----------------------------------------------------------------------------
module http_message_framer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            item_valid,
	output logic                            item_ready,
	input  hmf_pkg::in_item_t               item,
	// verdict channel
	output logic                            result_valid,
	input  logic                            result_ready,
	output hmf_pkg::out_item_t              result,
	// register writes
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [hmf_pkg::CFG_BITS-1:0]    cfg_data
);

	// length limits
	logic [hmf_pkg::HDR_BITS-1:0]  max_hdr_q;
	logic [hmf_pkg::BODY_BITS-1:0] max_body_q;

	// stays low through reset so nothing is taken before the block runs
	logic run_q;

	// input register
	logic               valid_s1;
	hmf_pkg::in_item_t  item_s1;

	// result register
	logic               result_valid_q;
	hmf_pkg::out_item_t result_q;

	logic                 can_go;
	logic                 fire_s1;
	logic                 is_check_s1;
	hmf_pkg::trk_ctrl_t   trk_ctrl;
	hmf_pkg::trk_state_t  trk_state;
	hmf_pkg::out_item_t   verdict;
	logic                 verdict_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q  <= hmf_pkg::MAX_HDR_RESET;
			max_body_q <= hmf_pkg::MAX_BODY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hmf_pkg::CFG_MAX_HDR:  max_hdr_q  <= cfg_data[hmf_pkg::HDR_BITS-1:0];
				hmf_pkg::CFG_MAX_BODY: max_body_q <= cfg_data[hmf_pkg::BODY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// a data byte never waits; a check waits only for the result register
	assign is_check_s1 = (item_s1.kind == hmf_pkg::KIND_CHECK);
	assign can_go      = !is_check_s1 || !result_valid_q || result_ready;
	assign fire_s1     = valid_s1 && can_go;
	assign item_ready  = run_q && (!valid_s1 || can_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// tracker steps on each data byte and clears on any final verdict
	assign trk_ctrl.take      = fire_s1 && !is_check_s1;
	assign trk_ctrl.clear     = fire_s1 && is_check_s1 && verdict_done;
	assign trk_ctrl.data_byte = item_s1.data_byte;

	hmf_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (trk_ctrl),
		.state  (trk_state)
	);

	hmf_verdict u_verdict (
		.state        (trk_state),
		.max_hdr      (max_hdr_q),
		.max_body     (max_body_q),
		.accept_short (item_s1.accept_short),
		.result       (verdict),
		.done         (verdict_done)
	);

	// result register, loaded by every check and held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && is_check_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_check_s1) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/hmf_checker.sv =====
// ----------------------------------------------------------------------------
// hmf_checker
// port-level checks on the http message framer core
// ----------------------------------------------------------------------------
`include "http_message_framer_core_macros.svh"

module hmf_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  hmf_pkg::in_item_t    item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  hmf_pkg::out_item_t   result
);

	// a stalled verdict holds
	`HMF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "verdict changed while stalled")

	// lengths only on complete
	`HMF_ASSERT_NOW(a_len_zero, result_valid && (result.status != hmf_pkg::ST_COMPLETE), (result.header_len == '0) && (result.body_len == '0), "lengths set on a non-complete verdict")

	// a complete header holds at least the terminator
	`HMF_ASSERT_NOW(a_hdr_min, result_valid && (result.status == hmf_pkg::ST_COMPLETE), result.header_len >= 4, "complete header shorter than terminator")

	// a fresh verdict follows an accepted check request
	`HMF_ASSERT_NOW(a_verdict_src, $rose(result_valid), $past(item_valid && item_ready && (item.kind == hmf_pkg::KIND_CHECK), 2), "verdict without a check request")

endmodule

bind http_message_framer_core hmf_checker u_hmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== test/tb_http_message_framer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http message framer core testbench
// feeds bytes of http messages with check requests in between, works out each
// verdict with its own framing tracker and compares every field on the result
// channel, across several length limit settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_http_message_framer_core;

	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TERM_SIZE   = 4;
	localparam int FIELD_SIZE  = 18;

	// progress through the content-length value
	typedef enum logic [2:0] {
		VAL_SEARCH,
		VAL_SPACE,
		VAL_SIGN,
		VAL_DIGITS,
		VAL_DONE
	} val_phase_e;

	// one row of the directed script
	typedef struct {
		hmf_pkg::in_item_t  req;
		bit                 fixed;
		hmf_pkg::out_item_t want;
	} script_row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	hmf_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_ready;
	hmf_pkg::out_item_t result;
	logic               cfg_we;
	logic [0:0]                   cfg_index;
	logic [hmf_pkg::CFG_BITS-1:0] cfg_data;

	// framing tracker of the testbench
	logic [hmf_pkg::CNT_BITS-1:0]  seen_cnt;
	int unsigned                   term_pos;
	bit                            hdr_seen;
	logic [hmf_pkg::CNT_BITS-1:0]  hdr_bytes;
	int unsigned                   field_pos;
	val_phase_e                    val_phase;
	bit                            val_neg;
	logic [hmf_pkg::MAG_BITS-1:0]  val_mag;
	logic [hmf_pkg::HDR_BITS-1:0]  lim_hdr;
	logic [hmf_pkg::BODY_BITS-1:0] lim_body;

	hmf_pkg::out_item_t verdict_q[$];
	script_row_t        script[$];
	logic [7:0]         msg_bytes[$];
	string              field_name = "Content-Length: ";

	int  err_count;
	int  cycle_count;
	int  items_sent;
	int  burst_left;
	bit  gaps_on;
	int  rx_mode;
	bit  hold_req;

	http_message_framer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// tracker
	// ------------------------------------------------------------------------

	// position 0 and 1 of the field name are cr lf, the rest is the text
	function automatic logic [7:0] field_char(input int unsigned pos);
		if (pos == 0)
			return hmf_pkg::CH_CR;
		if (pos == 1)
			return hmf_pkg::CH_LF;
		return field_name[pos-2];
	endfunction

	// both patterns repeat only their leading cr, so a miss restarts on cr
	function automatic int unsigned match_step(input int unsigned pos, input logic [7:0] want,
			input logic [7:0] c);
		if (want == c)
			return pos + 1;
		return (c == hmf_pkg::CH_CR) ? 1 : 0;
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return (c == hmf_pkg::CH_SPACE) || (c == hmf_pkg::CH_TAB) || (c == hmf_pkg::CH_LF) ||
			(c == hmf_pkg::CH_VT) || (c == hmf_pkg::CH_FF) || (c == hmf_pkg::CH_CR);
	endfunction

	function automatic void clear_tracker();
		seen_cnt  = '0;
		term_pos  = 0;
		hdr_seen  = 1'b0;
		hdr_bytes = '0;
		field_pos = 0;
		val_phase = VAL_SEARCH;
		val_neg   = 1'b0;
		val_mag   = '0;
	endfunction

	// atoi-style value parse: blanks, one sign, then saturating digits
	function automatic void parse_length(input logic [7:0] c);
		longint unsigned prod;
		bit digit;
		digit = (c >= hmf_pkg::CH_ZERO) && (c <= hmf_pkg::CH_NINE);
		if (val_phase == VAL_SPACE) begin
			if (blank_char(c))
				return;
			if ((c == hmf_pkg::CH_PLUS) || (c == hmf_pkg::CH_MINUS)) begin
				val_neg   = (c == hmf_pkg::CH_MINUS);
				val_phase = VAL_SIGN;
				return;
			end
		end
		if (!digit) begin
			val_phase = VAL_DONE;
			return;
		end
		val_phase = VAL_DIGITS;
		prod = longint'(val_mag) * 10 + longint'(c - hmf_pkg::CH_ZERO);
		val_mag = (prod > longint'(hmf_pkg::MAG_MAX)) ? hmf_pkg::MAG_MAX :
			prod[hmf_pkg::MAG_BITS-1:0];
	endfunction

	function automatic void absorb_byte(input logic [7:0] c);
		if (seen_cnt != hmf_pkg::CNT_MAX)
			seen_cnt = seen_cnt + 1'b1;
		if (hdr_seen)
			return;
		// the value is only read inside the headers
		if (val_phase == VAL_SEARCH) begin
			field_pos = match_step(field_pos, field_char(field_pos), c);
			if (field_pos == FIELD_SIZE)
				val_phase = VAL_SPACE;
		end else if (val_phase != VAL_DONE) begin
			parse_length(c);
		end
		term_pos = match_step(term_pos,
			(term_pos % 2 == 0) ? hmf_pkg::CH_CR : hmf_pkg::CH_LF, c);
		if (term_pos == TERM_SIZE) begin
			hdr_seen  = 1'b1;
			hdr_bytes = seen_cnt;
		end
	endfunction

	// verdict for a check request; any final verdict clears the tracker
	function automatic hmf_pkg::out_item_t judge_request(input bit force_done);
		hmf_pkg::out_item_t v;
		longint unsigned body;
		bit has_len;
		v = '0;
		v.status = hmf_pkg::ST_NEED_MORE;
		has_len = (val_phase != VAL_SEARCH);
		if (seen_cnt == 0) begin
			v.status = hmf_pkg::ST_NEED_MORE;
		end else if (!hdr_seen) begin
			v.status = (seen_cnt > lim_hdr) ? hmf_pkg::ST_HDR_LONG : hmf_pkg::ST_NEED_MORE;
		end else if (hdr_bytes >= lim_hdr) begin
			v.status = hmf_pkg::ST_HDR_LONG;
		end else begin
			body = longint'(seen_cnt) - longint'(hdr_bytes);
			if (body >= longint'(lim_body)) begin
				v.status = hmf_pkg::ST_BODY_LONG;
			end else if (has_len && val_neg && (val_mag != 0)) begin
				v.status = hmf_pkg::ST_NEGATIVE;
			end else if (has_len && (body < longint'(val_mag)) && !force_done) begin
				v.status = hmf_pkg::ST_NEED_MORE;
			end else begin
				if (has_len && (body > longint'(val_mag)))
					body = longint'(val_mag);
				v.status     = hmf_pkg::ST_COMPLETE;
				v.header_len = hdr_bytes[hmf_pkg::HDR_BITS-1:0];
				v.body_len   = body[hmf_pkg::BODY_BITS-1:0];
			end
		end
		if (v.status != hmf_pkg::ST_NEED_MORE)
			clear_tracker();
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d, at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// verdicts are sampled on the rising edge and matched in order
	always @(posedge clk) begin
		hmf_pkg::out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("verdict with none pending", longint'(result.status), -1);
			end else begin
				want = verdict_q.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", longint'(result.status),
						longint'(want.status));
				if (result.header_len !== want.header_len)
					report_mismatch("header_len", longint'(result.header_len),
						longint'(want.header_len));
				if (result.body_len !== want.body_len)
					report_mismatch("body_len", longint'(result.body_len),
						longint'(want.body_len));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// verdict side: own stall pattern, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int rx_tick;
		rx_tick = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up and stalls its requests
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				rx_tick++;
				case (rx_mode)
					0:       result_ready <= 1'b1;
					1:       result_ready <= 1'($urandom_range(0, 1));
					default: result_ready <= ((rx_tick % 7) < 4);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// one request: optional gap, hold valid until taken, then predict
	task automatic offer(input hmf_pkg::in_item_t r, input bit fixed,
			input hmf_pkg::out_item_t want);
		hmf_pkg::out_item_t v;
		if (burst_left == 0) begin
			if (gaps_on) begin
				repeat ($urandom_range(1, 6)) begin
					@(negedge clk);
					item_valid <= 1'b0;
				end
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		item       <= r;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		items_sent++;
		if (r.kind == hmf_pkg::KIND_DATA) begin
			absorb_byte(r.data_byte);
		end else begin
			v = judge_request(r.accept_short);
			verdict_q.push_back(fixed ? want : v);
		end
	endtask

	task automatic offer_byte(input logic [7:0] c);
		hmf_pkg::in_item_t r;
		r.kind         = hmf_pkg::KIND_DATA;
		r.data_byte    = c;
		r.accept_short = 1'($urandom_range(0, 1));
		offer(r, 1'b0, '0);
	endtask

	task automatic offer_check();
		hmf_pkg::in_item_t r;
		r.kind         = hmf_pkg::KIND_CHECK;
		r.data_byte    = 8'($urandom_range(0, 255));
		r.accept_short = 1'($urandom_range(0, 1));
		offer(r, 1'b0, '0);
	endtask

	// wait for every verdict, then idle with no request
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_limits(input logic [hmf_pkg::CFG_BITS-1:0] hdr,
			input logic [hmf_pkg::CFG_BITS-1:0] body);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= hmf_pkg::CFG_MAX_HDR;
		cfg_data  <= hdr;
		@(negedge clk);
		cfg_index <= hmf_pkg::CFG_MAX_BODY;
		cfg_data  <= body;
		@(negedge clk);
		cfg_we    <= 1'b0;
		lim_hdr  = hdr[hmf_pkg::HDR_BITS-1:0];
		lim_body = body[hmf_pkg::BODY_BITS-1:0];
	endtask

	task automatic add_row(input logic kind, input logic [7:0] c, input logic force_done,
			input bit fixed, input logic [2:0] st, input int hl, input int bl);
		script_row_t row;
		row.req.kind         = kind;
		row.req.data_byte    = c;
		row.req.accept_short = force_done;
		row.fixed            = fixed;
		row.want.status      = st;
		row.want.header_len  = hmf_pkg::HDR_BITS'(hl);
		row.want.body_len    = hmf_pkg::BODY_BITS'(bl);
		script.push_back(row);
	endtask

	function automatic logic [7:0] rand_letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endfunction

	// content-length value text; returns a rough length to size the body
	function automatic int add_value();
		logic [7:0] blanks [6];
		int v;
		int sel;
		blanks = '{hmf_pkg::CH_SPACE, hmf_pkg::CH_TAB, hmf_pkg::CH_VT, hmf_pkg::CH_FF,
			hmf_pkg::CH_CR, hmf_pkg::CH_LF};
		v = 0;
		repeat ($urandom_range(0, 2))
			msg_bytes.push_back(blanks[$urandom_range(0, 5)]);
		sel = $urandom_range(0, 3);
		if (sel == 2)
			msg_bytes.push_back(hmf_pkg::CH_PLUS);
		else if (sel == 3)
			msg_bytes.push_back(hmf_pkg::CH_MINUS);
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			// no digits at all
			msg_bytes.push_back(rand_letter());
		end else if (sel == 1) begin
			// far past the saturation point
			msg_bytes.push_back(8'(hmf_pkg::CH_ZERO + $urandom_range(1, 9)));
			repeat ($urandom_range(9, 12))
				msg_bytes.push_back(8'(hmf_pkg::CH_ZERO + $urandom_range(0, 9)));
			v = 30;
		end else begin
			v = $urandom_range(0, 40);
			if ($urandom_range(0, 4) == 0)
				msg_bytes.push_back(hmf_pkg::CH_ZERO);
			push_text($sformatf("%0d", v));
		end
		if ($urandom_range(0, 3) == 0)
			msg_bytes.push_back(rand_letter());
		return v;
	endfunction

	// mostly well-formed messages with random content, some broken
	function automatic void compose_message();
		int layout;
		int len_hint;
		msg_bytes.delete();
		len_hint = 8;
		repeat ($urandom_range(0, 6))
			msg_bytes.push_back(rand_letter());
		if ($urandom_range(0, 2) == 0) begin
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
			repeat ($urandom_range(1, 5))
				msg_bytes.push_back(rand_letter());
		end
		layout = $urandom_range(0, 9);
		if (layout <= 6) begin
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
			push_text(field_name);
			// misspelt field name: flip bit 5 of one character, mostly the case of a letter
			if (layout == 6)
				msg_bytes[msg_bytes.size() - 1 - $urandom_range(1, 15)] ^= 8'h20;
			len_hint = add_value();
		end
		if ($urandom_range(0, 2) == 0) begin
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
			repeat ($urandom_range(1, 5))
				msg_bytes.push_back(rand_letter());
		end
		// terminator, sometimes missing
		if ($urandom_range(0, 9) != 0) begin
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
		end
		// value that only appears after the headers
		if (layout == 8) begin
			msg_bytes.push_back(hmf_pkg::CH_CR);
			msg_bytes.push_back(hmf_pkg::CH_LF);
			push_text(field_name);
			msg_bytes.push_back(8'(hmf_pkg::CH_ZERO + 7));
		end
		repeat ($urandom_range(0, len_hint + 4))
			msg_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_message();
		compose_message();
		foreach (msg_bytes[i]) begin
			if ($urandom_range(0, 15) == 0)
				offer_check();
			offer_byte(msg_bytes[i]);
		end
		repeat ($urandom_range(1, 2))
			offer_check();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 24)) begin
			if ($urandom_range(0, 5) == 0)
				offer_check();
			else
				offer_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase_start;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = hmf_pkg::CFG_MAX_HDR;
		cfg_data   = '0;
		err_count  = 0;
		cycle_count = 0;
		items_sent = 0;
		burst_left = 0;
		gaps_on    = 1'b1;
		rx_mode    = 1;
		hold_req   = 1'b0;
		lim_hdr    = hmf_pkg::MAX_HDR_RESET;
		lim_body   = hmf_pkg::MAX_BODY_RESET;
		clear_tracker();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty check, bare terminator, odd bytes with no terminator,
		// short body without a length field, terminator after a false start
		add_row(hmf_pkg::KIND_CHECK, 8'h00, 1'b0, 1'b1, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b1, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_CHECK, 8'hFF, 1'b1, 1'b1, hmf_pkg::ST_COMPLETE, 4, 0);
		add_row(hmf_pkg::KIND_DATA, 8'hFF, 1'b1, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_CHECK, 8'h00, 1'b0, 1'b1, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, 8'h41, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, 8'h80, 1'b1, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_CHECK, 8'h7F, 1'b0, 1'b1, hmf_pkg::ST_COMPLETE, 6, 2);
		add_row(hmf_pkg::KIND_CHECK, 8'h00, 1'b1, 1'b1, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_CR, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_DATA, hmf_pkg::CH_LF, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		add_row(hmf_pkg::KIND_CHECK, 8'h00, 1'b0, 1'b0, hmf_pkg::ST_NEED_MORE, 0, 0);
		foreach (script[i])
			offer(script[i].req, script[i].fixed, script[i].want);

		// random phases, each under its own pair of limits
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: ; // reset limits
				1: write_limits(hmf_pkg::CFG_BITS'(4), hmf_pkg::CFG_BITS'(1));
				2: write_limits(hmf_pkg::CFG_BITS'(65535), hmf_pkg::CFG_BITS'(16777215));
				3: write_limits(hmf_pkg::CFG_BITS'($urandom_range(8, 60)),
					hmf_pkg::CFG_BITS'($urandom_range(2, 40)));
				// upper bits of the header limit are dropped by the register
				4: write_limits({8'hA5, 16'($urandom_range(0, 3))},
					hmf_pkg::CFG_BITS'($urandom_range(0, 16777215)));
				default: write_limits(hmf_pkg::CFG_BITS'($urandom_range(20, 120)),
					hmf_pkg::CFG_BITS'($urandom_range(10, 60)));
			endcase
			gaps_on = (phase % 3) != 2;
			rx_mode = phase % 3;
			if (phase == 2) begin
				// receiver holds off while requests keep coming back to back
				gaps_on  = 1'b0;
				hold_req = 1'b1;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					send_message();
			end
		end

		settle();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
